### src/srle_pkg.sv
// shared constants and types for the sprite row run-length encoder
`default_nettype none
package srle_pkg;

  localparam int ROW_MAX  = 32;
  localparam int ROWS_MAX = 1024;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(ROW_MAX);
  localparam int WIDTH_W = 6;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = COUNT_W;
  localparam int TDATA_W = 48;
  localparam int TUSER_W = 2;

  localparam logic [PIX_W-1:0] BYTE_EMPTY = 8'hff;
  localparam logic [PIX_W-1:0] BYTE_SOLID = 8'hfe;

  localparam logic CFG_ROW_WIDTH = 1'b0;
  localparam logic CFG_ROW_COUNT = 1'b1;

  typedef struct packed {
    logic               en;
    logic [COL_W-1:0]   addr;
    logic [PIX_W-1:0]   data;
  } ram_wr_t;

  typedef struct packed {
    logic               en;
    logic [COL_W-1:0]   addr;
  } ram_rd_t;

  typedef struct packed {
    logic               live;
    logic [COUNT_W-1:0] pend;
    logic [COL_W-1:0]   lead;
    logic [COL_W-1:0]   last_addr;
    logic               solid;
    logic [WIDTH_W-1:0] run;
    logic               frame_end;
    logic [COUNT_W-1:0] skipped;
    logic [COUNT_W-1:0] rows;
  } job_t;

endpackage
`default_nettype wire

### src/srle_row_ram.sv
// row pixel memory, one write port and one registered read port
`default_nettype none
module srle_row_ram (
  input  wire                       clk,
  input  srle_pkg::ram_wr_t         wr,
  input  srle_pkg::ram_rd_t         rd,
  output logic [srle_pkg::PIX_W-1:0] rdata
);

  logic [srle_pkg::PIX_W-1:0] mem [srle_pkg::ROW_MAX];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

### src/srle_scan.sv
// per-pixel row statistics and frame counters, launches row encode jobs
`default_nettype none
module srle_scan (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           pix_valid,
  input  wire  [srle_pkg::PIX_W-1:0]    pix,
  input  wire  [srle_pkg::WIDTH_W-1:0]  width_eff,
  input  wire  [srle_pkg::COUNT_W-1:0]  count_eff,
  output srle_pkg::ram_wr_t             wr,
  output logic                          job_start,
  output srle_pkg::job_t                job
);

  logic [srle_pkg::COL_W-1:0]   column;
  logic                         live;
  logic [srle_pkg::COL_W-1:0]   first_nz;
  logic [srle_pkg::COL_W-1:0]   last_nz;
  logic [srle_pkg::WIDTH_W-1:0] zeros_after;
  logic                         content_seen;
  logic [srle_pkg::COUNT_W-1:0] row_index;
  logic [srle_pkg::COUNT_W-1:0] skipped;
  logic [srle_pkg::COUNT_W-1:0] pending;
  logic [srle_pkg::COUNT_W-1:0] rows_out;

  logic                         nz;
  logic                         live_next;
  logic [srle_pkg::COL_W-1:0]   first_next;
  logic [srle_pkg::COL_W-1:0]   last_next;
  logic [srle_pkg::WIDTH_W-1:0] zeros_next;
  logic [srle_pkg::WIDTH_W-1:0] col_plus;
  logic                         row_end;
  logic [srle_pkg::COL_W-1:0]   trailing;
  logic [srle_pkg::COUNT_W-1:0] index_next;
  logic                         frame_end;
  logic [srle_pkg::COUNT_W-1:0] skipped_next;
  logic [srle_pkg::COUNT_W-1:0] pending_next;
  logic [srle_pkg::COUNT_W-1:0] rows_next;

  always_comb begin
    nz         = (pix != '0);
    live_next  = live | nz;
    first_next = (!live && nz) ? column : first_nz;
    last_next  = nz ? column : last_nz;
    zeros_next = (!nz && live) ? zeros_after + 1'b1 : zeros_after;
    col_plus   = {{(srle_pkg::WIDTH_W-srle_pkg::COL_W){1'b0}}, column} + 1'b1;
    row_end    = (col_plus >= width_eff);
    trailing   = column - last_next;
    index_next = row_index + 1'b1;
    frame_end  = (index_next >= count_eff);
    if (live_next) begin
      skipped_next = skipped;
      pending_next = '0;
      rows_next    = rows_out + pending + 1'b1;
    end else begin
      skipped_next = content_seen ? skipped : skipped + 1'b1;
      pending_next = content_seen ? pending + 1'b1 : pending;
      rows_next    = rows_out;
    end
  end

  assign wr.en   = pix_valid;
  assign wr.addr = column;
  assign wr.data = pix;

  assign job_start = pix_valid && row_end && (live_next || frame_end);

  assign job.live      = live_next;
  assign job.pend      = pending;
  assign job.lead      = first_next;
  assign job.last_addr = last_next;
  assign job.solid     = (zeros_next == {{(srle_pkg::WIDTH_W-srle_pkg::COL_W){1'b0}}, trailing});
  assign job.run       = {{(srle_pkg::WIDTH_W-srle_pkg::COL_W){1'b0}}, last_next - first_next}
                         + 1'b1;
  assign job.frame_end = frame_end;
  assign job.skipped   = skipped_next;
  assign job.rows      = rows_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      live         <= 1'b0;
      first_nz     <= '0;
      last_nz      <= '0;
      zeros_after  <= '0;
      content_seen <= 1'b0;
      row_index    <= '0;
      skipped      <= '0;
      pending      <= '0;
      rows_out     <= '0;
    end else if (pix_valid) begin
      if (!row_end) begin
        column      <= col_plus[srle_pkg::COL_W-1:0];
        live        <= live_next;
        first_nz    <= first_next;
        last_nz     <= last_next;
        zeros_after <= zeros_next;
      end else begin
        column      <= '0;
        live        <= 1'b0;
        first_nz    <= '0;
        last_nz     <= '0;
        zeros_after <= '0;
        if (frame_end) begin
          content_seen <= 1'b0;
          row_index    <= '0;
          skipped      <= '0;
          pending      <= '0;
          rows_out     <= '0;
        end else begin
          content_seen <= content_seen | live_next;
          row_index    <= index_next;
          skipped      <= skipped_next;
          pending      <= pending_next;
          rows_out     <= rows_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/srle_emit.sv
// row encode sequencer, reads the row memory and drives the result register
`default_nettype none
module srle_emit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           job_start,
  input  srle_pkg::job_t                job_in,
  output logic                          idle,
  output srle_pkg::ram_rd_t             rd,
  input  wire  [srle_pkg::PIX_W-1:0]    rdata,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [srle_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast,
  output logic [srle_pkg::TUSER_W-1:0]  m_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEND,
    S_LEAD,
    S_SOLID,
    S_RUN,
    S_DATA,
    S_NULL
  } state_t;

  state_t                       state;
  srle_pkg::job_t               job;
  logic [srle_pkg::COL_W-1:0]   cur;

  logic [srle_pkg::PIX_W-1:0]   out_byte;
  logic                         byte_valid;
  logic [srle_pkg::COUNT_W-1:0] repeat_res;
  logic                         frame_done;
  logic [srle_pkg::COUNT_W-1:0] leading_empty;
  logic [srle_pkg::COUNT_W-1:0] encoded_rows;

  logic                         adv;
  logic                         data_final;

  assign adv        = !m_tvalid || m_tready;
  assign data_final = (cur == job.last_addr);
  assign idle       = (state == S_IDLE);

  always_comb begin
    rd.en   = 1'b0;
    rd.addr = job.lead;
    if (adv && state == S_RUN) begin
      rd.en   = 1'b1;
      rd.addr = job.lead;
    end else if (adv && state == S_DATA && !data_final) begin
      rd.en   = 1'b1;
      rd.addr = cur + 1'b1;
    end
  end

  assign m_tdata = {{(srle_pkg::TDATA_W - srle_pkg::PIX_W - 3*srle_pkg::COUNT_W){1'b0}},
                    encoded_rows, leading_empty, repeat_res, out_byte};
  assign m_tuser = {frame_done, byte_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (state == S_IDLE) begin
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (job_start) begin
          job <= job_in;
          if (!job_in.live) begin
            state <= S_NULL;
          end else if (job_in.pend != '0) begin
            state <= S_PEND;
          end else begin
            state <= S_LEAD;
          end
        end
      end else if (adv) begin
        m_tvalid      <= 1'b1;
        m_tlast       <= 1'b0;
        byte_valid    <= 1'b1;
        repeat_res    <= {{(srle_pkg::COUNT_W-1){1'b0}}, 1'b1};
        frame_done    <= job.frame_end;
        leading_empty <= job.frame_end ? job.skipped : '0;
        encoded_rows  <= job.frame_end ? job.rows : '0;
        unique case (state)
          S_PEND: begin
            out_byte   <= srle_pkg::BYTE_EMPTY;
            repeat_res <= job.pend;
            state      <= S_LEAD;
          end
          S_LEAD: begin
            out_byte <= {{(srle_pkg::PIX_W-srle_pkg::COL_W){1'b0}}, job.lead};
            state    <= job.solid ? S_SOLID : S_RUN;
          end
          S_SOLID: begin
            out_byte <= srle_pkg::BYTE_SOLID;
            state    <= S_RUN;
          end
          S_RUN: begin
            out_byte <= {{(srle_pkg::PIX_W-srle_pkg::WIDTH_W){1'b0}}, job.run};
            cur      <= job.lead;
            state    <= S_DATA;
          end
          S_DATA: begin
            out_byte <= rdata;
            if (data_final) begin
              m_tlast <= 1'b1;
              state   <= S_IDLE;
            end else begin
              cur <= cur + 1'b1;
            end
          end
          S_NULL: begin
            out_byte   <= '0;
            byte_valid <= 1'b0;
            m_tlast    <= 1'b1;
            state      <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### src/sprite_row_rle_encoder.sv
// sprite row encoder with transparent run trimming and empty-row markers
//
// pixels enter on the s_ group, one 8-bit colour per request, raster order.
// each complete row with content is encoded on the m_ group: lead byte,
// optional 0xfe, run length and run bytes, preceded by one 0xff with a
// repeat count for held empty rows. tlast marks the final result of the
// pixel that caused it. the cfg channel sets row width and row count; the
// user must write it only while idle; the block does not enforce this.
// the row-closing pixel writes the row memory, then the sequencer emits its
// k results (up to width plus four), one per cycle while the receiver is
// ready, through the output register, reading run bytes from the row
// memory's registered read port; s_tready is low meanwhile. the closing
// pixel starts the sequencer, whose first state then loads the first
// result into the output register. when the receiver stalls, the output
// register holds and the sequencer waits. reset clears all counters and
// the sequencer; the row memory needs no clearing since every byte read
// was written in the same row.
`default_nettype none
module sprite_row_rle_encoder (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [srle_pkg::PIX_W-1:0]    s_tdata,   // pixel
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // out_byte, repeat_res, leading_empty, encoded_rows, zero fill
  output logic [srle_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast,
  output logic [srle_pkg::TUSER_W-1:0]  m_tuser,   // byte_valid, frame_done
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire                           cfg_index,
  input  wire  [srle_pkg::CFG_W-1:0]    cfg_data
);

  logic [srle_pkg::WIDTH_W-1:0] row_width;
  logic [srle_pkg::COUNT_W-1:0] row_count;
  logic [srle_pkg::WIDTH_W-1:0] width_eff;
  logic [srle_pkg::COUNT_W-1:0] count_eff;

  logic                         pix_valid;
  logic                         idle;
  logic                         job_start;
  srle_pkg::job_t               job;
  srle_pkg::ram_wr_t            wr;
  srle_pkg::ram_rd_t            rd;
  logic [srle_pkg::PIX_W-1:0]   rdata;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign pix_valid = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= srle_pkg::WIDTH_W'(srle_pkg::ROW_MAX);
      row_count <= srle_pkg::COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srle_pkg::CFG_ROW_WIDTH: row_width <= cfg_data[srle_pkg::WIDTH_W-1:0];
        srle_pkg::CFG_ROW_COUNT: row_count <= cfg_data[srle_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_width == '0) begin
      width_eff = srle_pkg::WIDTH_W'(1);
    end else if (row_width > srle_pkg::WIDTH_W'(srle_pkg::ROW_MAX)) begin
      width_eff = srle_pkg::WIDTH_W'(srle_pkg::ROW_MAX);
    end else begin
      width_eff = row_width;
    end
    if (row_count == '0) begin
      count_eff = srle_pkg::COUNT_W'(1);
    end else if (row_count > srle_pkg::COUNT_W'(srle_pkg::ROWS_MAX)) begin
      count_eff = srle_pkg::COUNT_W'(srle_pkg::ROWS_MAX);
    end else begin
      count_eff = row_count;
    end
  end

  srle_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (s_tdata),
    .width_eff (width_eff),
    .count_eff (count_eff),
    .wr        (wr),
    .job_start (job_start),
    .job       (job)
  );

  srle_row_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  srle_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_start (job_start),
    .job_in    (job),
    .idle      (idle),
    .rd        (rd),
    .rdata     (rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

### dv/sprite_row_rle_encoder_tb.sv
// self-checking testbench for the sprite row run-length encoder
`timescale 1ns / 1ps
module sprite_row_rle_encoder_tb;
  import srle_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES   = 16;

  typedef struct {
    logic [PIX_W-1:0]   out_byte;
    logic               byte_valid;
    logic [COUNT_W-1:0] repeat_res;
    logic               last;
    logic               frame_done;
    logic [COUNT_W-1:0] leading_empty;
    logic [COUNT_W-1:0] encoded_rows;
  } enc_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [PIX_W-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tlast;
  logic [TUSER_W-1:0]  m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_ROW_WIDTH;
  logic [CFG_W-1:0]    cfg_data = '0;

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int fail_count = 0;

  // predictor state
  logic [WIDTH_W-1:0]  cur_width = 6'd32;
  logic [COUNT_W-1:0]  cur_count = 11'd1;
  logic [PIX_W-1:0]    row_buf [ROW_MAX];
  logic [WIDTH_W-1:0]  col = '0;
  logic [COUNT_W-1:0]  row_idx = '0;
  logic                row_live = 1'b0;
  logic [WIDTH_W-1:0]  first_nz = '0;
  logic [WIDTH_W-1:0]  last_nz = '0;
  logic [WIDTH_W-1:0]  zeros_after = '0;
  logic                content_seen = 1'b0;
  logic [COUNT_W-1:0]  skipped = '0;
  logic [COUNT_W-1:0]  pending = '0;
  logic [COUNT_W-1:0]  rows_done = '0;

  enc_result_t expected_bytes [$];
  enc_result_t want, seen;

  sprite_row_rle_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic enc_result_t make_byte(input logic [PIX_W-1:0] b, input logic v,
                                            input logic [COUNT_W-1:0] rep);
    enc_result_t r;
    r.out_byte      = b;
    r.byte_valid    = v;
    r.repeat_res    = rep;
    r.last          = 1'b0;
    r.frame_done    = 1'b0;
    r.leading_empty = '0;
    r.encoded_rows  = '0;
    return r;
  endfunction

  function automatic void encode_pixel(input logic [PIX_W-1:0] pix);
    enc_result_t burst [$];
    enc_result_t r;
    int w, h, idx, run, trailing, inner, i;
    w = (cur_width < 1) ? 1 : ((cur_width > ROW_MAX) ? ROW_MAX : int'(cur_width));
    h = (cur_count < 1) ? 1 : ((cur_count > ROWS_MAX) ? ROWS_MAX : int'(cur_count));
    idx = (col >= ROW_MAX) ? ROW_MAX - 1 : int'(col);
    row_buf[idx] = pix;
    if (pix != 0) begin
      if (!row_live) begin
        first_nz = WIDTH_W'(idx);
        row_live = 1'b1;
      end
      last_nz = WIDTH_W'(idx);
    end else if (row_live) begin
      zeros_after = zeros_after + 1'b1;
    end
    col = WIDTH_W'(idx + 1);
    if (col < w) return;

    if (!row_live) begin
      if (!content_seen) skipped = skipped + 1'b1;
      else pending = pending + 1'b1;
    end else begin
      run = int'(last_nz) - int'(first_nz) + 1;
      trailing = int'(col) - 1 - int'(last_nz);
      inner = int'(zeros_after) - trailing;
      content_seen = 1'b1;
      if (pending != 0) begin
        burst.push_back(make_byte(BYTE_EMPTY, 1'b1, pending));
        rows_done = rows_done + pending;
        pending = '0;
      end
      burst.push_back(make_byte(8'(first_nz), 1'b1, 11'd1));
      if (inner == 0) burst.push_back(make_byte(BYTE_SOLID, 1'b1, 11'd1));
      burst.push_back(make_byte(8'(run), 1'b1, 11'd1));
      for (i = first_nz; i <= last_nz; i++) burst.push_back(make_byte(row_buf[i], 1'b1, 11'd1));
      rows_done = rows_done + 1'b1;
    end
    col = '0;
    row_live = 1'b0;
    first_nz = '0;
    last_nz = '0;
    zeros_after = '0;
    row_idx = row_idx + 1'b1;

    if (row_idx >= h) begin
      if (burst.size() == 0) burst.push_back(make_byte('0, 1'b0, 11'd1));
      for (i = 0; i < burst.size(); i++) begin
        r = burst[i];
        r.frame_done = 1'b1;
        r.leading_empty = skipped;
        r.encoded_rows = rows_done;
        burst[i] = r;
      end
      row_idx = '0;
      content_seen = 1'b0;
      skipped = '0;
      pending = '0;
      rows_done = '0;
    end
    for (i = 0; i < burst.size(); i++) begin
      r = burst[i];
      r.last = (i == burst.size() - 1);
      expected_bytes.push_back(r);
    end
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    encode_pixel(pix);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (!hold) cfg_valid <= 1'b0;
    if (idx == CFG_ROW_WIDTH) cur_width = val[WIDTH_W-1:0];
    else cur_count = val[COUNT_W-1:0];
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_row(input int w);
    int kind, lo, hi, i;
    logic [PIX_W-1:0] pix;
    kind = $urandom_range(9);
    lo = $urandom_range(w - 1);
    hi = $urandom_range(w - 1, lo);
    for (i = 0; i < w; i++) begin
      if (kind == 9) pix = $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0;
      else if (kind < 3 || i < lo || i > hi) pix = 8'd0;
      else if (kind < 6) pix = 8'($urandom_range(255, 1));
      else pix = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
      push_pixel(pix);
    end
  endtask

  // skipped top row, inner zero, held empty row, solid run, trailing empty row
  task automatic test_row_shapes();
    logic [PIX_W-1:0] px [20];
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 4, 1'b1);
    write_reg(CFG_ROW_COUNT, 5, 1'b0);
    px = '{8'd0, 8'd0, 8'd0, 8'd0,
           8'd0, 8'd5, 8'd0, 8'd7,
           8'd0, 8'd0, 8'd0, 8'd0,
           8'hff, 8'hfe, 8'd1, 8'd0,
           8'd0, 8'd0, 8'd0, 8'd0};
    foreach (px[i]) push_pixel(px[i]);
  endtask

  task automatic test_range_clamp();
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 0, 1'b1);
    write_reg(CFG_ROW_COUNT, 0, 1'b0);
    push_pixel(8'd0);
    push_pixel(8'd128);
  endtask

  task automatic test_width_cut();
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 6, 1'b1);
    write_reg(CFG_ROW_COUNT, 2, 1'b0);
    push_pixel(8'd9);
    push_pixel(8'd0);
    push_pixel(8'd3);
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 2, 1'b0);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'd0);
  endtask

  task automatic test_count_cut();
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 1, 1'b1);
    write_reg(CFG_ROW_COUNT, ROWS_MAX, 1'b0);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'd7);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'd200);
    wait_idle();
    write_reg(CFG_ROW_COUNT, 2047, 1'b0);
    push_pixel(8'd0);
    wait_idle();
    write_reg(CFG_ROW_COUNT, 3, 1'b0);
    push_pixel(8'd5);
  endtask

  task automatic test_random_frames(input int budget);
    int sent, w_reg, c_reg, w_eff, c_eff, r;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0: w_reg = 0;
        1: w_reg = ROW_MAX;
        2: w_reg = $urandom_range(63, ROW_MAX + 1);
        default: w_reg = $urandom_range(8, 1);
      endcase
      w_eff = (w_reg < 1) ? 1 : ((w_reg > ROW_MAX) ? ROW_MAX : w_reg);
      if (w_eff == ROW_MAX) c_reg = $urandom_range(3, 1);
      else if (w_eff <= 2 && $urandom_range(3) == 0) c_reg = $urandom_range(60, 20);
      else c_reg = $urandom_range(6, 0);
      c_eff = (c_reg < 1) ? 1 : c_reg;
      wait_idle();
      write_reg(CFG_ROW_WIDTH, w_reg, 1'b1);
      write_reg(CFG_ROW_COUNT, c_reg, 1'b0);
      for (r = 0; r < c_eff; r++) push_row(w_eff);
      sent += w_eff * c_eff;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.out_byte      = m_tdata[7:0];
      seen.repeat_res    = m_tdata[18:8];
      seen.leading_empty = m_tdata[29:19];
      seen.encoded_rows  = m_tdata[40:30];
      seen.byte_valid    = m_tuser[0];
      seen.frame_done    = m_tuser[1];
      seen.last          = m_tlast;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.out_byte, seen.out_byte);
        check_field("byte_valid", want.byte_valid, seen.byte_valid);
        check_field("repeat_res", want.repeat_res, seen.repeat_res);
        check_field("last", want.last, seen.last);
        check_field("frame_done", want.frame_done, seen.frame_done);
        check_field("leading_empty", want.leading_empty, seen.leading_empty);
        check_field("encoded_rows", want.encoded_rows, seen.encoded_rows);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("sprite_row_rle_encoder test failed");
    $finish;
  end

  initial begin
    foreach (row_buf[i]) row_buf[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    rcv_stall_pct = 54;
    test_row_shapes();
    test_range_clamp();
    test_width_cut();
    test_count_cut();
    test_random_frames(75);
    send_idle_pct = 54;
    rcv_stall_pct = 26;
    test_random_frames(75);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    test_random_frames(75);
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected results never arrived", expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("sprite_row_rle_encoder test passed");
    else
      $display("sprite_row_rle_encoder test failed");
    $finish;
  end

endmodule
